// File: hdl/pch_pkg.sv
`timescale 1ns / 1ps
package pch_pkg;

    localparam int OP_W    = 2;
    localparam int FIELD_W = 32;
    localparam int TOTAL_W = 13;
    localparam int MOD_W   = 13;
    localparam int CFG_AW  = 1;

    typedef logic [OP_W-1:0]    t_op;
    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [CFG_AW-1:0]  t_cfg_addr;

    localparam t_op OP_ADD    = 2'd0;
    localparam t_op OP_SUB    = 2'd1;
    localparam t_op OP_CLEAR  = 2'd2;
    localparam t_op OP_UNUSED = 2'd3;

    localparam t_cfg_addr REG_MODULUS = 1'd0;
    localparam t_cfg_addr REG_MULT    = 1'd1;

    localparam logic [MOD_W-1:0]   MODULUS_RESET = 13'd4093;
    localparam logic [FIELD_W-1:0] MULT_RESET    = 32'd16777213;

endpackage

// File: hdl/pch_ifs.sv
`timescale 1ns / 1ps
interface pch_in_if;
    import pch_pkg::*;
    logic   valid;
    logic   ready;
    t_op    operation;
    t_field left_symbol;
    t_field right_symbol;
    t_field amount;
    modport source(output valid, operation, left_symbol, right_symbol, amount, input ready);
    modport sink(input valid, operation, left_symbol, right_symbol, amount, output ready);
endinterface

interface pch_out_if;
    import pch_pkg::*;
    logic               valid;
    logic               ready;
    t_field             max_count;
    t_field             max_left;
    t_field             max_right;
    logic               max_valid;
    logic               pair_found;
    logic               table_full;
    logic [TOTAL_W-1:0] entry_total;
    modport source(output valid, max_count, max_left, max_right, max_valid, pair_found,
                   table_full, entry_total, input ready);
    modport sink(input valid, max_count, max_left, max_right, max_valid, pair_found,
                 table_full, entry_total, output ready);
endinterface

interface pch_cfg_if;
    import pch_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_addr addr;
    t_field    data;
    modport source(output valid, addr, data, input ready);
    modport sink(input valid, addr, data, output ready);
endinterface

// File: hdl/pch_ram.sv
`timescale 1ns / 1ps
module pch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;
endmodule

// File: hdl/pair_count_hash_table_top.sv
`timescale 1ns / 1ps
// Pair counter on a chained hash table. Each word adds to or subtracts from the count of a
// (left, right) symbol pair, clears the table, or (with the unused operation code) changes
// nothing, and yields one status word. For an add or subtract the bucket is found by a
// one-bit-per-cycle remainder unit (left symbol first, then product plus right symbol), and
// the chain is walked one read of the entry memory at a time. A clear sweeps the entry,
// bucket and free-stack memories, and after reset the same sweep runs over them before the
// first word is taken. Configuration writes are accepted at any time.
module pair_count_hash_table_top #(
    parameter int TABLE_SIZE  = 4096,
    parameter int SYMBOL_BITS = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pch_in_if.sink    i_in,
    pch_out_if.source o_out,
    pch_cfg_if.sink   i_cfg
);
    import pch_pkg::*;

    localparam int AW    = $clog2(TABLE_SIZE);
    localparam int CW    = AW + 1;
    localparam int DW    = AW + 33;
    localparam int BW    = $clog2(DW + 1);
    localparam int SB    = SYMBOL_BITS;
    localparam int CT_LO = 2 * SB;
    localparam int LK_LO = CT_LO + COUNT_BITS;
    localparam int US    = LK_LO + CW;
    localparam int EW    = US + 1;

    localparam logic [CW-1:0] NIL = CW'(TABLE_SIZE);
    localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);
    localparam logic [FIELD_W-1:0] CNT_MAX32 = FIELD_W'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_MODL    = 4'd2;
    localparam logic [3:0] S_MUL     = 4'd3;
    localparam logic [3:0] S_MODH    = 4'd4;
    localparam logic [3:0] S_HEAD    = 4'd5;
    localparam logic [3:0] S_HREAD   = 4'd6;
    localparam logic [3:0] S_CHECK   = 4'd7;
    localparam logic [3:0] S_ECMP    = 4'd8;
    localparam logic [3:0] S_RESOLVE = 4'd9;
    localparam logic [3:0] S_POP     = 4'd10;
    localparam logic [3:0] S_UNLINK  = 4'd11;
    localparam logic [3:0] S_BEST    = 4'd12;
    localparam logic [3:0] S_BWAIT   = 4'd13;

    logic [3:0]            r_state;
    logic [AW-1:0]         r_idx;
    logic                  r_clear_item;
    logic [MOD_W-1:0]      r_modulus;
    logic [FIELD_W-1:0]    r_mult;
    t_op                   r_op;
    logic [SB-1:0]         r_left;
    logic [SB-1:0]         r_right;
    logic [COUNT_BITS-1:0] r_amt;
    logic [DW-1:0]         r_div;
    logic [BW-1:0]         r_bits;
    logic [AW-1:0]         r_rem;
    logic [CW-1:0]         r_head;
    logic [CW-1:0]         r_pos;
    logic [AW-1:0]         r_prev;
    logic                  r_prev_nil;
    logic [EW-1:0]         r_word;
    logic [EW-1:0]         r_prev_word;
    logic [CW-1:0]         r_free;
    logic [CW-1:0]         r_entries;
    logic [COUNT_BITS-1:0] r_best;
    logic [AW-1:0]         r_best_idx;
    logic                  r_found;
    logic                  r_full;

    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_max_count;
    logic [FIELD_W-1:0]    r_max_left;
    logic [FIELD_W-1:0]    r_max_right;
    logic                  r_max_valid;
    logic                  r_pair_found;
    logic                  r_table_full;
    logic [TOTAL_W-1:0]    r_entry_total;

    logic                  ent_we, head_we, stk_we;
    logic [AW-1:0]         ent_wa, head_wa, stk_wa, ent_ra;
    logic [EW-1:0]         ent_wd, ent_q;
    logic [CW-1:0]         head_wd, head_q;
    logic [AW-1:0]         stk_wd, stk_q;

    logic [CW-1:0]         m_eff;
    logic [CW-1:0]         rem_shift;
    logic [AW-1:0]         rem_next;
    logic [AW+31:0]        prod;
    logic [FIELD_W-1:0]    amt_clamped;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] cnt_add, cnt_sub, word_cnt;
    logic [CW-1:0]         word_link;
    logic                  key_match;
    logic                  out_free;

    // Out-of-range moduli are folded into 1..TABLE_SIZE.
    always_comb begin
        if (r_modulus == '0) begin
            m_eff = CW'(1);
        end else if (32'(r_modulus) > 32'(TABLE_SIZE)) begin
            m_eff = NIL;
        end else begin
            m_eff = CW'(r_modulus);
        end
    end

    // One restoring step of the remainder unit, most significant dividend bit first.
    assign rem_shift = {r_rem, r_div[DW-1]};
    assign rem_next  = (rem_shift >= m_eff) ? AW'(rem_shift - m_eff) : AW'(rem_shift);
    assign prod      = r_rem * r_mult;

    assign amt_clamped = (i_in.amount > CNT_MAX32) ? CNT_MAX32 : i_in.amount;
    assign word_cnt    = r_word[CT_LO +: COUNT_BITS];
    assign word_link   = r_word[LK_LO +: CW];
    assign sum         = {1'b0, word_cnt} + {1'b0, r_amt};
    assign cnt_add     = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    assign cnt_sub     = (word_cnt > r_amt) ? word_cnt - r_amt : '0;
    assign key_match   = (ent_q[SB-1:0] == r_left) && (ent_q[SB +: SB] == r_right);
    assign out_free    = !r_out_valid || o_out.ready;

    always_comb begin
        ent_we  = 1'b0;
        ent_wa  = r_pos[AW-1:0];
        ent_wd  = {1'b1, word_link, cnt_add, r_word[CT_LO-1:0]};
        head_we = 1'b0;
        head_wa = r_rem;
        head_wd = word_link;
        stk_we  = 1'b0;
        stk_wa  = r_free[AW-1:0];
        stk_wd  = r_pos[AW-1:0];
        ent_ra  = r_pos[AW-1:0];
        case (r_state)
            S_INIT: begin
                ent_we  = 1'b1;
                ent_wa  = r_idx;
                ent_wd  = {1'b0, NIL, {(COUNT_BITS + CT_LO){1'b0}}};
                head_we = 1'b1;
                head_wa = r_idx;
                head_wd = NIL;
                stk_we  = 1'b1;
                stk_wa  = r_idx;
                stk_wd  = LAST - r_idx;
            end
            S_RESOLVE: begin
                if (r_found) begin
                    ent_we = 1'b1;
                    if (r_op == OP_SUB) begin
                        if (cnt_sub != '0) begin
                            ent_wd = {1'b1, word_link, cnt_sub, r_word[CT_LO-1:0]};
                        end else begin
                            ent_wd  = {1'b0, NIL, {COUNT_BITS{1'b0}}, r_word[CT_LO-1:0]};
                            head_we = r_prev_nil;
                            stk_we  = (r_free < NIL);
                        end
                    end
                end
            end
            S_POP: begin
                ent_we  = 1'b1;
                ent_wa  = stk_q;
                ent_wd  = {1'b1, r_head, r_amt, r_right, r_left};
                head_we = 1'b1;
                head_wd = {1'b0, stk_q};
            end
            S_UNLINK: begin
                ent_we = 1'b1;
                ent_wa = r_prev;
                ent_wd = {r_prev_word[US], word_link, r_prev_word[LK_LO-1:0]};
            end
            S_BEST, S_BWAIT: begin
                ent_ra = r_best_idx;
            end
            default: begin
                ent_we = 1'b0;
            end
        endcase
    end

    pch_ram #(.WIDTH(EW), .DEPTH(TABLE_SIZE)) u_entry_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ent_we),
        .i_wr_addr(ent_wa),
        .i_wr_data(ent_wd),
        .i_rd_addr(ent_ra),
        .o_rd_data(ent_q)
    );

    pch_ram #(.WIDTH(CW), .DEPTH(TABLE_SIZE)) u_head_ram (
        .i_clk    (i_clk),
        .i_wr_en  (head_we),
        .i_wr_addr(head_wa),
        .i_wr_data(head_wd),
        .i_rd_addr(r_rem),
        .o_rd_data(head_q)
    );

    pch_ram #(.WIDTH(AW), .DEPTH(TABLE_SIZE)) u_stack_ram (
        .i_clk    (i_clk),
        .i_wr_en  (stk_we),
        .i_wr_addr(stk_wa),
        .i_wr_data(stk_wd),
        .i_rd_addr(AW'(r_free - CW'(1))),
        .o_rd_data(stk_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
            r_mult    <= MULT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                REG_MODULUS: r_modulus <= i_cfg.data[MOD_W-1:0];
                REG_MULT:    r_mult    <= i_cfg.data;
                default:     r_mult    <= r_mult;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_idx        <= '0;
            r_clear_item <= 1'b0;
            r_free       <= NIL;
            r_entries    <= '0;
            r_best       <= '0;
            r_best_idx   <= '0;
            r_found      <= 1'b0;
            r_full       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == S_BWAIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == LAST) begin
                        r_state <= r_clear_item ? S_BEST : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.operation;
                        r_left  <= i_in.left_symbol[SB-1:0];
                        r_right <= i_in.right_symbol[SB-1:0];
                        r_amt   <= COUNT_BITS'(amt_clamped);
                        r_div   <= {i_in.left_symbol[SB-1:0], {(DW - SB){1'b0}}};
                        r_bits  <= BW'(SB);
                        r_rem   <= '0;
                        r_found <= 1'b0;
                        r_full  <= 1'b0;
                        if (i_in.operation == OP_CLEAR) begin
                            r_state      <= S_INIT;
                            r_idx        <= '0;
                            r_clear_item <= 1'b1;
                            r_free       <= NIL;
                            r_entries    <= '0;
                            r_best       <= '0;
                            r_best_idx   <= '0;
                        end else if (i_in.operation == OP_ADD || i_in.operation == OP_SUB) begin
                            r_state <= S_MODL;
                        end else begin
                            r_state <= S_BEST;
                        end
                    end
                end
                S_MODL: begin
                    r_rem  <= rem_next;
                    r_div  <= r_div << 1;
                    r_bits <= r_bits - BW'(1);
                    if (r_bits == BW'(1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_div   <= DW'(prod) + DW'(r_right);
                    r_bits  <= BW'(DW);
                    r_rem   <= '0;
                    r_state <= S_MODH;
                end
                S_MODH: begin
                    r_rem  <= rem_next;
                    r_div  <= r_div << 1;
                    r_bits <= r_bits - BW'(1);
                    if (r_bits == BW'(1)) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_state <= S_HREAD;
                end
                S_HREAD: begin
                    r_head     <= head_q;
                    r_pos      <= head_q;
                    r_prev_nil <= 1'b1;
                    r_state    <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= (r_pos >= NIL) ? S_RESOLVE : S_ECMP;
                end
                S_ECMP: begin
                    if (key_match) begin
                        r_word  <= ent_q;
                        r_found <= 1'b1;
                        r_state <= S_RESOLVE;
                    end else begin
                        r_prev      <= r_pos[AW-1:0];
                        r_prev_word <= ent_q;
                        r_prev_nil  <= 1'b0;
                        r_pos       <= ent_q[LK_LO +: CW];
                        r_state     <= S_CHECK;
                    end
                end
                S_RESOLVE: begin
                    r_state <= S_BEST;
                    if (r_op == OP_ADD) begin
                        if (r_found) begin
                            if (cnt_add > r_best) begin
                                r_best     <= cnt_add;
                                r_best_idx <= r_pos[AW-1:0];
                            end
                        end else if (r_free == '0) begin
                            r_full <= 1'b1;
                        end else begin
                            r_free  <= r_free - CW'(1);
                            r_state <= S_POP;
                        end
                    end else if (r_found && cnt_sub == '0) begin
                        if (r_free < NIL) begin
                            r_free <= r_free + CW'(1);
                        end
                        if (r_entries != '0) begin
                            r_entries <= r_entries - CW'(1);
                        end
                        if (!r_prev_nil) begin
                            r_state <= S_UNLINK;
                        end
                    end
                end
                S_POP: begin
                    r_entries <= r_entries + CW'(1);
                    if (r_amt > r_best) begin
                        r_best     <= r_amt;
                        r_best_idx <= stk_q;
                    end
                    r_state <= S_BEST;
                end
                S_UNLINK: begin
                    r_state <= S_BEST;
                end
                S_BEST: begin
                    r_state <= S_BWAIT;
                end
                S_BWAIT: begin
                    if (out_free) begin
                        r_clear_item <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result word payload, loaded when the entry of the maximum has been read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_BWAIT && out_free) begin
            r_max_count   <= FIELD_W'(r_best);
            r_max_left    <= ent_q[US] ? FIELD_W'(ent_q[SB-1:0]) : '0;
            r_max_right   <= ent_q[US] ? FIELD_W'(ent_q[SB +: SB]) : '0;
            r_max_valid   <= ent_q[US];
            r_pair_found  <= r_found;
            r_table_full  <= r_full;
            r_entry_total <= TOTAL_W'(32'(r_entries));
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.max_count   = r_max_count;
    assign o_out.max_left    = r_max_left;
    assign o_out.max_right   = r_max_right;
    assign o_out.max_valid   = r_max_valid;
    assign o_out.pair_found  = r_pair_found;
    assign o_out.table_full  = r_table_full;
    assign o_out.entry_total = r_entry_total;

endmodule
